// ----- src/binned_running_mean_defines.svh -----
// ----------------------------------------------------------------------------
// binned_running_mean_defines
// Assertion macros shared by the binned running mean block.
// ----------------------------------------------------------------------------
`ifndef BINNED_RUNNING_MEAN_DEFINES_SVH
`define BINNED_RUNNING_MEAN_DEFINES_SVH

// check a consequent in the same cycle
`define BRM_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// check a consequent in the next cycle
`define BRM_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- src/brm_pkg.sv -----
// ----------------------------------------------------------------------------
// brm_pkg
// Types, codes and defaults for the binned running mean block.
// ----------------------------------------------------------------------------
`default_nettype none

package brm_pkg;

  localparam int BUCKETS_DEF     = 256;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF  = 16;

  localparam logic [1:0] REQ_CAPTURE = 2'd0;
  localparam logic [1:0] REQ_QUERY   = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  typedef enum logic [1:0] {
    DSEL_BUCKET,
    DSEL_LEFT,
    DSEL_RIGHT
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_CLR,
    ST_BDIV,
    ST_RD,
    ST_FOLD,
    ST_LDIV,
    ST_LWAIT,
    ST_RDIV,
    ST_RWAIT,
    ST_WR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     sweep;
    logic     accept;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_b;
    logic     mem_rd;
    logic     fold;
    logic     take_l;
    logic     take_r;
    logic     mem_wr;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_req;
    logic [1:0] req;
    logic       sweep_last;
    logic       div_done;
    logic       acc_l;
    logic       acc_r;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- src/brm_div.sv -----
// ----------------------------------------------------------------------------
// brm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_div #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic      [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign fits     = rem_sh >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- src/brm_ctrl.sv -----
// ----------------------------------------------------------------------------
// brm_ctrl
// Request sequencer: clearing sweep, capture, query and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire brm_pkg::status_t  status,
  output brm_pkg::cmd_t          cmd,
  output logic                   in_stall,
  output brm_pkg::state_t        state
);

  brm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brm_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = brm_pkg::DSEL_BUCKET;
    in_stall    = 1'b1;
    case (state)
      brm_pkg::ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) state_next = brm_pkg::ST_IDLE;
      end
      brm_pkg::ST_CLR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) state_next = brm_pkg::ST_OUT;
      end
      brm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (status.in_valid) begin
          cmd.accept = 1'b1;
          case (status.in_req)
            brm_pkg::REQ_CAPTURE: state_next = brm_pkg::ST_BDIV;
            brm_pkg::REQ_QUERY:   state_next = brm_pkg::ST_RD;
            brm_pkg::REQ_CLEAR:   state_next = brm_pkg::ST_CLR;
            default:              state_next = brm_pkg::ST_IDLE;
          endcase
        end
      end
      brm_pkg::ST_BDIV: begin
        cmd.take_b = 1'b1;
        state_next = brm_pkg::ST_RD;
      end
      brm_pkg::ST_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = brm_pkg::ST_FOLD;
      end
      brm_pkg::ST_FOLD: begin
        if (status.req == brm_pkg::REQ_QUERY) begin
          state_next = brm_pkg::ST_OUT;
        end else begin
          cmd.fold   = 1'b1;
          state_next = brm_pkg::ST_LDIV;
        end
      end
      brm_pkg::ST_LDIV: begin
        if (status.acc_l) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = brm_pkg::DSEL_LEFT;
          state_next    = brm_pkg::ST_LWAIT;
        end else begin
          state_next = brm_pkg::ST_RDIV;
        end
      end
      brm_pkg::ST_LWAIT: begin
        if (status.div_done) begin
          cmd.take_l = 1'b1;
          state_next = brm_pkg::ST_RDIV;
        end
      end
      brm_pkg::ST_RDIV: begin
        if (status.acc_r) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = brm_pkg::DSEL_RIGHT;
          state_next    = brm_pkg::ST_RWAIT;
        end else begin
          state_next = brm_pkg::ST_WR;
        end
      end
      brm_pkg::ST_RWAIT: begin
        if (status.div_done) begin
          cmd.take_r = 1'b1;
          state_next = brm_pkg::ST_WR;
        end
      end
      brm_pkg::ST_WR: begin
        cmd.mem_wr = 1'b1;
        state_next = brm_pkg::ST_OUT;
      end
      brm_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = brm_pkg::ST_IDLE;
        end
      end
      default: state_next = brm_pkg::ST_SWEEP;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/brm_dp.sv -----
// ----------------------------------------------------------------------------
// brm_dp
// Bucket stores, fold arithmetic, shared divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_dp #(
  parameter int BUCKETS     = brm_pkg::BUCKETS_DEF,
  parameter int SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = brm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire brm_pkg::cmd_t                 cmd,
  output brm_pkg::status_t                   status,
  input  wire logic                          in_valid,
  input  wire logic [1:0]                    req_type,
  input  wire logic [15:0]                   position,
  input  wire logic signed [SAMPLE_BITS-1:0] value_left,
  input  wire logic                          left_present,
  input  wire logic signed [SAMPLE_BITS-1:0] value_right,
  input  wire logic                          right_present,
  input  wire logic [7:0]                    query_bucket,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         bucket_index,
  output logic signed [SAMPLE_BITS-1:0]      mean_left,
  output logic                               left_valid,
  output logic signed [SAMPLE_BITS-1:0]      mean_right,
  output logic                               right_valid,
  output logic [8:0]                         filled_buckets
);

  localparam int BW       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IW       = (BW > 8) ? BW : 8;
  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam int PM_W     = 16 + BW + 1;
  localparam int NUM_W    = SUM_BITS + 1;
  localparam int DEN_W    = COUNT_BITS;
  localparam int FW       = $clog2(BUCKETS + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic signed [SUM_BITS-1:0]    sum_l_mem [BUCKETS];
  logic signed [SUM_BITS-1:0]    sum_r_mem [BUCKETS];
  logic [COUNT_BITS-1:0]         cnt_l_mem [BUCKETS];
  logic [COUNT_BITS-1:0]         cnt_r_mem [BUCKETS];
  logic signed [SAMPLE_BITS-1:0] mean_l_mem [BUCKETS];
  logic signed [SAMPLE_BITS-1:0] mean_r_mem [BUCKETS];

  logic [1:0]                    req;
  logic [PM_W-1:0]               pos_m;
  logic signed [SAMPLE_BITS-1:0] val_l;
  logic signed [SAMPLE_BITS-1:0] val_r;
  logic                          pres_l;
  logic                          pres_r;
  logic [BW-1:0]                 qaddr;
  logic [7:0]                    qidx;
  logic                          q_oor;
  logic [BW-1:0]                 bucket;
  logic [BW-1:0]                 sweep_addr;
  logic [FW-1:0]                 filled;

  logic signed [SUM_BITS-1:0]    sum_l_rd, sum_r_rd, sum_l_new, sum_r_new;
  logic [COUNT_BITS-1:0]         cnt_l_rd, cnt_r_rd, cnt_l_new, cnt_r_new;
  logic signed [SAMPLE_BITS-1:0] mean_l_rd, mean_r_rd, mean_l_new, mean_r_new;
  logic                          acc_l, acc_r;

  logic [BW-1:0]        rd_addr;
  logic [PM_W:0]        pos_q;
  logic [SUM_BITS:0]    mag_l, mag_r;
  logic [NUM_W-1:0]     div_num;
  logic [DEN_W-1:0]     div_den;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quo;
  logic signed [SAMPLE_BITS-1:0] quo_s;
  logic                 out_free;
  logic [IW-1:0]        q_ext;

  assign q_ext   = IW'(query_bucket);
  assign rd_addr = (req == brm_pkg::REQ_QUERY) ? qaddr : bucket;
  // divide by 65535 through the 2^16-1 identity, exact below 2^32
  assign pos_q   = ({1'b0, pos_m} + (PM_W+1)'(pos_m >> 16) + (PM_W+1)'(1)) >> 16;
  assign mag_l   = sum_l_new[SUM_BITS-1] ? (SUM_BITS+1)'(-{sum_l_new[SUM_BITS-1], sum_l_new})
                                         : {1'b0, sum_l_new};
  assign mag_r   = sum_r_new[SUM_BITS-1] ? (SUM_BITS+1)'(-{sum_r_new[SUM_BITS-1], sum_r_new})
                                         : {1'b0, sum_r_new};
  assign quo_s   = SAMPLE_BITS'(div_quo);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (cmd.div_sel)
      brm_pkg::DSEL_LEFT: begin
        div_num = NUM_W'(mag_l + (SUM_BITS+1)'(cnt_l_new >> 1));
        div_den = DEN_W'(cnt_l_new);
      end
      brm_pkg::DSEL_RIGHT: begin
        div_num = NUM_W'(mag_r + (SUM_BITS+1)'(cnt_r_new >> 1));
        div_den = DEN_W'(cnt_r_new);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  brm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req    <= req_type;
      pos_m  <= PM_W'(position) * PM_W'(BUCKETS - 1) + PM_W'(32767);
      val_l  <= value_left;
      val_r  <= value_right;
      pres_l <= left_present;
      pres_r <= right_present;
      qaddr  <= BW'(q_ext);
      qidx   <= query_bucket;
      q_oor  <= 32'(q_ext) >= 32'(BUCKETS);
    end
    if (cmd.take_b) begin
      bucket <= (pos_q > (PM_W+1)'(BUCKETS - 1)) ? BW'(BUCKETS - 1) : BW'(pos_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      sum_l_mem[sweep_addr]  <= '0;
      sum_r_mem[sweep_addr]  <= '0;
      cnt_l_mem[sweep_addr]  <= '0;
      cnt_r_mem[sweep_addr]  <= '0;
      mean_l_mem[sweep_addr] <= '0;
      mean_r_mem[sweep_addr] <= '0;
    end else if (cmd.mem_wr) begin
      sum_l_mem[bucket]  <= sum_l_new;
      sum_r_mem[bucket]  <= sum_r_new;
      cnt_l_mem[bucket]  <= cnt_l_new;
      cnt_r_mem[bucket]  <= cnt_r_new;
      mean_l_mem[bucket] <= mean_l_new;
      mean_r_mem[bucket] <= mean_r_new;
    end
    if (cmd.mem_rd) begin
      sum_l_rd  <= sum_l_mem[rd_addr];
      sum_r_rd  <= sum_r_mem[rd_addr];
      cnt_l_rd  <= cnt_l_mem[rd_addr];
      cnt_r_rd  <= cnt_r_mem[rd_addr];
      mean_l_rd <= mean_l_mem[rd_addr];
      mean_r_rd <= mean_r_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fold) begin
      sum_l_new  <= sum_l_rd;
      cnt_l_new  <= cnt_l_rd;
      mean_l_new <= mean_l_rd;
      sum_r_new  <= sum_r_rd;
      cnt_r_new  <= cnt_r_rd;
      mean_r_new <= mean_r_rd;
      if (acc_l) begin
        sum_l_new <= sum_l_rd + SUM_BITS'(val_l);
        cnt_l_new <= cnt_l_rd + 1'b1;
      end
      if (acc_r) begin
        sum_r_new <= sum_r_rd + SUM_BITS'(val_r);
        cnt_r_new <= cnt_r_rd + 1'b1;
      end
    end
    if (cmd.take_l) mean_l_new <= sum_l_new[SUM_BITS-1] ? -quo_s : quo_s;
    if (cmd.take_r) mean_r_new <= sum_r_new[SUM_BITS-1] ? -quo_s : quo_s;
  end

  assign acc_l = pres_l && (cnt_l_rd != COUNT_MAX);
  assign acc_r = pres_r && (cnt_r_rd != COUNT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      filled     <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= (sweep_addr == BW'(BUCKETS - 1)) ? '0 : sweep_addr + 1'b1;
      filled     <= '0;
    end else if (cmd.mem_wr) begin
      if ((acc_l || acc_r) && cnt_l_rd == '0 && cnt_r_rd == '0) begin
        filled <= filled + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filled_buckets <= 9'(filled);
      case (req)
        brm_pkg::REQ_CAPTURE: begin
          bucket_index <= 8'(bucket);
          mean_left    <= mean_l_new;
          left_valid   <= cnt_l_new != '0;
          mean_right   <= mean_r_new;
          right_valid  <= cnt_r_new != '0;
        end
        brm_pkg::REQ_QUERY: begin
          bucket_index <= qidx;
          mean_left    <= q_oor ? '0 : mean_l_rd;
          left_valid   <= !q_oor && cnt_l_rd != '0;
          mean_right   <= q_oor ? '0 : mean_r_rd;
          right_valid  <= !q_oor && cnt_r_rd != '0;
        end
        default: begin
          bucket_index <= '0;
          mean_left    <= '0;
          left_valid   <= 1'b0;
          mean_right   <= '0;
          right_valid  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    status            = '0;
    status.in_valid   = in_valid;
    status.in_req     = req_type;
    status.req        = req;
    status.sweep_last = sweep_addr == BW'(BUCKETS - 1);
    status.div_done   = div_done;
    status.acc_l      = acc_l;
    status.acc_r      = acc_r;
    status.out_free   = out_free;
  end

endmodule

`default_nettype wire

// ----- src/binned_running_mean.sv -----
// ----------------------------------------------------------------------------
// binned_running_mean
// Per-bucket running mean of two signed channels over a sweep position.
// ----------------------------------------------------------------------------
// One word is taken at a time. After reset the block sweeps its stores one
// bucket a cycle with in_stall high, and a clear does the same. A capture
// first finds its bucket and then runs the shared one-bit-per-cycle divider
// on a NUM_W-bit dividend, NUM_W = SAMPLE_BITS+COUNT_BITS+1, for each
// accepted channel; a channel that is absent or saturated skips its divide.
// A request of the unused code is taken with no result. The result register
// lets the next word in while a result waits on out_stall.
`default_nettype none

`include "binned_running_mean_defines.svh"

module binned_running_mean #(
  parameter int BUCKETS     = brm_pkg::BUCKETS_DEF,
  parameter int SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = brm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    req_type,
  input  wire logic [15:0]                   position,
  input  wire logic signed [SAMPLE_BITS-1:0] value_left,
  input  wire logic                          left_present,
  input  wire logic signed [SAMPLE_BITS-1:0] value_right,
  input  wire logic                          right_present,
  input  wire logic [7:0]                    query_bucket,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         bucket_index,
  output logic signed [SAMPLE_BITS-1:0]      mean_left,
  output logic                               left_valid,
  output logic signed [SAMPLE_BITS-1:0]      mean_right,
  output logic                               right_valid,
  output logic [8:0]                         filled_buckets
);

  brm_pkg::cmd_t    cmd;
  brm_pkg::status_t status;
  brm_pkg::state_t  state;

  brm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall),
    .state    (state)
  );

  brm_dp #(
    .BUCKETS     (BUCKETS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_valid       (in_valid),
    .req_type       (req_type),
    .position       (position),
    .value_left     (value_left),
    .left_present   (left_present),
    .value_right    (value_right),
    .right_present  (right_present),
    .query_bucket   (query_bucket),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bucket_index   (bucket_index),
    .mean_left      (mean_left),
    .left_valid     (left_valid),
    .mean_right     (mean_right),
    .right_valid    (right_valid),
    .filled_buckets (filled_buckets)
  );

  `BRM_ASSERT_NOW(a_stall_busy, clk, rst, state != brm_pkg::ST_IDLE, in_stall)
  `BRM_ASSERT_NOW(a_left_zero, clk, rst, out_valid && !left_valid, mean_left == '0)
  `BRM_ASSERT_NOW(a_right_zero, clk, rst, out_valid && !right_valid, mean_right == '0)
  `BRM_ASSERT_NOW(a_load_free, clk, rst, cmd.load_out, !out_valid || !out_stall)

endmodule

`default_nettype wire
